// File: design/irc_tok_pkg.sv
// Shared types and constants for the IRC line tokenizer.
// Used by irc_tok_core and irc_line_tokenizer_top; depends on nothing else.
package irc_tok_pkg;

  localparam int unsigned MaxParamsDef = 16;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;

  localparam logic [2:0] KindDelim  = 3'd0;
  localparam logic [2:0] KindSource = 3'd1;
  localparam logic [2:0] KindCmd    = 3'd2;
  localparam logic [2:0] KindMiddle = 3'd3;
  localparam logic [2:0] KindTrail  = 3'd4;

  localparam logic [1:0] ErrNone     = 2'd0;
  localparam logic [1:0] ErrEmptySrc = 2'd1;
  localparam logic [1:0] ErrNoCmd    = 2'd2;
  localparam logic [1:0] ErrTooMany  = 2'd3;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] field_kind;
    logic [3:0] param_index;
    logic       token_start;
    logic       line_done;
    logic [1:0] error_code;
    logic [4:0] param_total;
    logic       has_trailing;
  } result_t;

endpackage

// File: design/irc_tok_core.sv
// Per-byte classifier of the IRC line tokenizer: line phase, parameter count
// and error state. Uses irc_tok_pkg.
module irc_tok_core #(
  parameter int unsigned MaxParams = irc_tok_pkg::MaxParamsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 end_of_line_i,
  output irc_tok_pkg::result_t result_o
);
  import irc_tok_pkg::*;

  localparam int unsigned CntW = $clog2(MaxParams + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxParams);

  typedef enum logic [2:0] {
    PhLineStart = 3'd0,
    PhSrcFirst  = 3'd1,
    PhInSrc     = 3'd2,
    PhSepCmd    = 3'd3,
    PhInCmd     = 3'd4,
    PhSepParam  = 3'd5,
    PhInMiddle  = 3'd6,
    PhInTrail   = 3'd7
  } phase_e;

  phase_e          phase_q, phase_d, phase_step;
  logic [CntW-1:0] count_q, count_d, count_step;
  logic [1:0]      err_q, err_d, err_step;
  logic            trail_q, trail_d, trail_step;

  logic            is_space, is_colon, sat;
  logic [CntW-1:0] open_cnt, open_idx, idx_full;
  logic [CntW+3:0] idx_ext;
  logic [CntW+4:0] cnt_ext;
  logic [2:0]      kind;
  logic            start;

  assign is_space = (data_byte_i == ChSpace);
  assign is_colon = (data_byte_i == ChColon);

  // A new parameter past the limit reuses the last slot and flags an overflow.
  assign sat      = (count_q >= CntMax);
  assign open_cnt = sat ? CntMax : count_q + CntW'(1);
  assign open_idx = open_cnt - CntW'(1);

  always_comb begin
    phase_step = phase_q;
    count_step = count_q;
    err_step   = err_q;
    trail_step = trail_q;
    kind       = KindDelim;
    idx_full   = '0;
    start      = 1'b0;
    case (phase_q)
      PhLineStart: begin
        if (is_colon) begin
          kind = KindSource; start = 1'b1; phase_step = PhSrcFirst;
        end else if (is_space) begin
          phase_step = PhSepCmd;
        end else begin
          kind = KindCmd; start = 1'b1; phase_step = PhInCmd;
        end
      end
      PhSrcFirst: begin
        if (is_space) begin
          if (err_q == ErrNone) err_step = ErrEmptySrc;
          phase_step = PhSepCmd;
        end else begin
          kind = KindSource; phase_step = PhInSrc;
        end
      end
      PhInSrc: begin
        if (is_space) phase_step = PhSepCmd;
        else kind = KindSource;
      end
      PhSepCmd: begin
        if (!is_space) begin
          kind = KindCmd; start = 1'b1; phase_step = PhInCmd;
        end
      end
      PhInCmd: begin
        if (is_space) phase_step = PhSepParam;
        else kind = KindCmd;
      end
      PhSepParam: begin
        if (!is_space) begin
          start      = 1'b1;
          idx_full   = open_idx;
          count_step = open_cnt;
          if (sat && err_q == ErrNone) err_step = ErrTooMany;
          if (is_colon) begin
            kind = KindTrail; trail_step = 1'b1; phase_step = PhInTrail;
          end else begin
            kind = KindMiddle; phase_step = PhInMiddle;
          end
        end
      end
      PhInMiddle: begin
        if (is_space) begin
          phase_step = PhSepParam;
        end else begin
          kind = KindMiddle; idx_full = count_q - CntW'(1);
        end
      end
      PhInTrail: begin
        kind = KindTrail; idx_full = count_q - CntW'(1);
      end
      default: begin
        phase_step = PhLineStart;
      end
    endcase
  end

  // Line-end checks look at the phase after this byte.
  always_comb begin
    err_d   = err_step;
    phase_d = phase_step;
    count_d = count_step;
    trail_d = trail_step;
    if (end_of_line_i) begin
      if (phase_step == PhSrcFirst && err_d == ErrNone) err_d = ErrEmptySrc;
      if ((phase_step == PhLineStart || phase_step == PhSrcFirst ||
           phase_step == PhInSrc || phase_step == PhSepCmd) && err_d == ErrNone) begin
        err_d = ErrNoCmd;
      end
    end
  end

  assign idx_ext = {4'b0000, idx_full};
  assign cnt_ext = {5'b00000, count_step};

  always_comb begin
    result_o.byte_out     = data_byte_i;
    result_o.field_kind   = kind;
    result_o.param_index  = idx_ext[3:0];
    result_o.token_start  = start;
    result_o.line_done    = end_of_line_i;
    result_o.error_code   = end_of_line_i ? err_d : ErrNone;
    result_o.param_total  = end_of_line_i ? cnt_ext[4:0] : 5'd0;
    result_o.has_trailing = end_of_line_i & trail_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLineStart;
      count_q <= '0;
      err_q   <= ErrNone;
      trail_q <= 1'b0;
    end else if (advance_i) begin
      if (end_of_line_i) begin
        phase_q <= PhLineStart;
        count_q <= '0;
        err_q   <= ErrNone;
        trail_q <= 1'b0;
      end else begin
        phase_q <= phase_d;
        count_q <= count_d;
        err_q   <= err_d;
        trail_q <= trail_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The count never passes the limit.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("parameter count above limit");

  // Inside a parameter at least one parameter has been opened.
  a_param_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhInMiddle || phase_q == PhInTrail) |-> count_q != '0)
    else $error("parameter phase with zero count");

  // A trailing parameter is only ever in progress once it has been flagged.
  a_trail_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhInTrail |-> trail_q)
    else $error("trailing phase without trailing flag");
`endif

endmodule

// File: design/irc_line_tokenizer_top.sv
// Each accepted byte's result is registered in the output register, or in the skid register
// while the output is held. Throughput: one byte per cycle while in_stall_o is low; an output
// register plus a skid register keep input acceptance going while one result waits downstream.
// Reset (rst_ni low, asynchronous): line state returns to start of line, both
// result registers empty. Uses irc_tok_pkg and irc_tok_core.
module irc_line_tokenizer_top #(
  parameter int unsigned MaxParams = irc_tok_pkg::MaxParamsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_line_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic [2:0] field_kind_o,
  output logic [3:0] param_index_o,
  output logic       token_start_o,
  output logic       line_done_o,
  output logic [1:0] error_code_o,
  output logic [4:0] param_total_o,
  output logic       has_trailing_o
);
  import irc_tok_pkg::*;

  result_t res_new, out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    in_accept, out_take;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i & ~skid_valid_q;
  assign out_take   = out_valid_q & ~out_stall_i;

  irc_tok_core #(
    .MaxParams(MaxParams)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (in_accept),
    .data_byte_i  (data_byte_i),
    .end_of_line_i(end_of_line_i),
    .result_o     (res_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take || !out_valid_q) begin
      skid_valid_q <= 1'b0;
      out_valid_q  <= skid_valid_q | in_accept;
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload registers; the skid register catches a beat while the output is held.
  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res_new;
    end else if (in_accept) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_out_o     = out_q.byte_out;
  assign field_kind_o   = out_q.field_kind;
  assign param_index_o  = out_q.param_index;
  assign token_start_o  = out_q.token_start;
  assign line_done_o    = out_q.line_done;
  assign error_code_o   = out_q.error_code;
  assign param_total_o  = out_q.param_total;
  assign has_trailing_o = out_q.has_trailing;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid register filled without a held output");

  a_summary_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.line_done) |->
      (out_q.error_code == ErrNone && out_q.param_total == 5'd0 && !out_q.has_trailing))
    else $error("summary fields set on a beat that does not end the line");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.field_kind <= KindTrail)
    else $error("field kind out of range");
`endif

endmodule
